FILE: sv/vxm_pkg.sv
// ----------------------------------------------------------------------------
// vxm_pkg
// Shared constants for the voxel successor mask block: grid defaults,
// opcodes, configuration register indexes and field widths.
// ----------------------------------------------------------------------------
package vxm_pkg;

  localparam int GRID_X_DEF = 16;
  localparam int GRID_Y_DEF = 16;
  localparam int GRID_Z_DEF = 16;

  localparam int OP_W    = 2;
  localparam int POS_W   = 4;
  localparam int SIZE_W  = 5;
  localparam int MASK_W  = 26;
  localparam int CIDX_W  = 2;
  localparam int CDATA_W = 5;

  localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

  localparam logic [CIDX_W-1:0] REG_X_SIZE = 2'd0;
  localparam logic [CIDX_W-1:0] REG_Y_SIZE = 2'd1;
  localparam logic [CIDX_W-1:0] REG_Z_SIZE = 2'd2;

  localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

endpackage

FILE: sv/vxm_ram.sv
// ----------------------------------------------------------------------------
// vxm_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module vxm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/voxel_move_successor_mask.sv
// ----------------------------------------------------------------------------
// voxel_move_successor_mask
// 3D occupancy grid with write, read and 26-neighbor legal move query.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries opcode, pos_x/y/z and
//   write_value. Each accepted item yields exactly one result on the output
//   channel (out_valid/out_stall): cell_blocked and move_mask.
//   Config writes (cfg_valid/cfg_ready, cfg_index, cfg_data) set x/y/z_size;
//   cfg_ready is always high; the user must make writes only while the block
//   is idle, as the block itself does not enforce it. The map is stored as
//   rows along x, one memory word per (y,z). Every item reads the 3x3 block
//   of rows around its cell through the single read port, one row a cycle,
//   then finishes (write-back of the modified row for a write). The next
//   item is taken once the result is loaded.
//   A finished result waits in the output register while out_stall is high;
//   the block stays in its final step until that register is free.
//   After reset a clearing pass zeroes all GRID_Y*GRID_Z rows of the map
//   (256 by default), one row a cycle; in_stall is high meanwhile.
// ----------------------------------------------------------------------------
module voxel_move_successor_mask #(
  parameter int GRID_X = vxm_pkg::GRID_X_DEF,
  parameter int GRID_Y = vxm_pkg::GRID_Y_DEF,
  parameter int GRID_Z = vxm_pkg::GRID_Z_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [vxm_pkg::OP_W-1:0]    opcode,
  input  logic [vxm_pkg::POS_W-1:0]   pos_x,
  input  logic [vxm_pkg::POS_W-1:0]   pos_y,
  input  logic [vxm_pkg::POS_W-1:0]   pos_z,
  input  logic                        write_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        cell_blocked,
  output logic [vxm_pkg::MASK_W-1:0]  move_mask,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [vxm_pkg::CIDX_W-1:0]  cfg_index,
  input  logic [vxm_pkg::CDATA_W-1:0] cfg_data
);
  import vxm_pkg::*;

  localparam int DEPTH = GRID_Y * GRID_Z;
  localparam int AW    = $clog2(DEPTH);
  localparam int XW    = $clog2(GRID_X);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_RUN   = 3'd2;
  localparam logic [2:0] S_LAST  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [2:0]        state;
  logic [AW-1:0]     clr_addr;
  logic [SIZE_W-1:0] x_size, y_size, z_size;
  logic [SIZE_W-1:0] ext_x, ext_y, ext_z;

  logic [OP_W-1:0]   op_r;
  logic [POS_W-1:0]  x_r, y_r, z_r;
  logic              wv_r;
  logic [1:0]        cy, cz, cy_d, cz_d;
  logic              cap_valid;
  logic [26:0]       nb;
  logic [GRID_X-1:0] center_word;

  logic              mem_we;
  logic [AW-1:0]     mem_waddr, mem_raddr, center_addr;
  logic [GRID_X-1:0] mem_wdata, mem_rdata;

  logic [SIZE_W-1:0] yy, zz, yy_d, zz_d, xc, yc, zc;
  logic              center_in;
  logic [MASK_W-1:0] mask_calc;
  logic              in_xfer, out_free;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // active extents, saturated to the grid
  assign ext_x = (9'(x_size) < 9'(GRID_X)) ? x_size : SIZE_W'(GRID_X);
  assign ext_y = (9'(y_size) < 9'(GRID_Y)) ? y_size : SIZE_W'(GRID_Y);
  assign ext_z = (9'(z_size) < 9'(GRID_Z)) ? z_size : SIZE_W'(GRID_Z);

  assign xc = SIZE_W'(x_r);
  assign yc = SIZE_W'(y_r);
  assign zc = SIZE_W'(z_r);
  assign center_in = (xc < ext_x) && (yc < ext_y) && (zc < ext_z);
  assign center_addr = AW'(32'(yc) + 32'(GRID_Y) * 32'(zc));

  // neighbor row coordinates; minus one wraps to 31, which is out of range
  assign yy = yc + SIZE_W'(cy) - SIZE_W'(1);
  assign zz = zc + SIZE_W'(cz) - SIZE_W'(1);

  always_comb begin
    if ((yy < ext_y) && (zz < ext_z)) begin
      mem_raddr = AW'(32'(yy) + 32'(GRID_Y) * 32'(zz));
    end else begin
      mem_raddr = '0;
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = center_addr;
    mem_wdata = center_word;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (state == S_FIN && out_free && op_r == OP_WRITE && center_in) begin
      mem_we = 1'b1;
      mem_wdata[XW'(xc)] = wv_r;
    end
  end

  vxm_ram #(
    .WIDTH(GRID_X),
    .DEPTH(DEPTH)
  ) u_map (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      cy        <= '0;
      cz        <= '0;
      cap_valid <= 1'b0;
      out_valid <= 1'b0;
      x_size    <= SIZE_RESET;
      y_size    <= SIZE_RESET;
      z_size    <= SIZE_RESET;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_X_SIZE: x_size <= cfg_data;
          REG_Y_SIZE: y_size <= cfg_data;
          REG_Z_SIZE: z_size <= cfg_data;
          default: ;
        endcase
      end
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      cap_valid <= (state == S_RUN);
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_xfer) begin
            cy    <= '0;
            cz    <= '0;
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (cz == 2'd2) begin
            cz <= '0;
            cy <= cy + 2'd1;
          end else begin
            cz <= cz + 2'd1;
          end
          if (cy == 2'd2 && cz == 2'd2) begin
            state <= S_LAST;
          end
        end
        S_LAST: state <= S_FIN;
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // item and capture registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r <= opcode;
      x_r  <= pos_x;
      y_r  <= pos_y;
      z_r  <= pos_z;
      wv_r <= write_value;
    end
    cy_d <= cy;
    cz_d <= cz;
    yy_d <= yy;
    zz_d <= zz;
    if (cap_valid) begin
      for (int dx = 0; dx < 3; dx++) begin
        nb[9*dx + 3*int'(cy_d) + int'(cz_d)] <=
          ((xc + SIZE_W'(dx) - SIZE_W'(1)) >= ext_x) || (yy_d >= ext_y) ||
          (zz_d >= ext_z) || mem_rdata[XW'(xc + SIZE_W'(dx) - SIZE_W'(1))];
      end
      if (cy_d == 2'd1 && cz_d == 2'd1) begin
        center_word <= mem_rdata;
      end
    end
    if (state == S_FIN && out_free) begin
      cell_blocked <= (op_r == OP_READ || op_r == OP_QUERY) ? nb[13] : 1'b0;
      move_mask    <= (op_r == OP_QUERY) ? mask_calc : '0;
    end
  end

  // a move is legal when all eight corners of its box are free
  always_comb begin
    int k;
    k = 0;
    mask_calc = '0;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        for (int c = 0; c < 3; c++) begin
          if (!(a == 1 && b == 1 && c == 1)) begin
            mask_calc[k] = !(nb[13] | nb[9*a+3*b+c] | nb[9*a+4] | nb[10+3*b] |
                             nb[9+3+c] | nb[9*a+3*b+1] | nb[9*a+3+c] |
                             nb[9+3*b+c]);
            k = k + 1;
          end
        end
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_CLEAR || state == S_FIN))
    else $error("map written outside clear or finish");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && move_mask != '0 |-> !cell_blocked)
    else $error("moves reported from a blocked cell");

  assert property (@(posedge clk) disable iff (rst)
    cap_valid |-> (state == S_RUN || state == S_LAST))
    else $error("row data captured outside the read sweep");

  assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> !in_stall == 1'b0)
    else $error("second transfer taken while item in flight");

endmodule
